@@ design/whist_pkg.sv @@
// Shared types and constants for the weighted histogram table.
package whist_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int CFG_W = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ACT_SET   = 3'd0,
    ACT_INC   = 3'd1,
    ACT_ADD   = 3'd2,
    ACT_SCALE = 3'd3,
    ACT_QUERY = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SCALE = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              valid_idx;
    logic [1:0]        wmode;
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] operand;
  } cmd_t;

  localparam logic [1:0] WM_SET = 2'd0;
  localparam logic [1:0] WM_INC = 2'd1;
  localparam logic [1:0] WM_ADD = 2'd2;

  localparam logic signed [39:0] TOT_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] TOT_MIN = 40'sh80_0000_0000;
  localparam logic signed [17:0] PROB_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] PROB_MIN = 18'sh20000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    if (v > 48'(TOT_MAX)) return TOT_MAX;
    if (v < 48'(TOT_MIN)) return TOT_MIN;
    return v[39:0];
  endfunction

endpackage

@@ design/whist_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface whist_req_if import whist_pkg::*; (input logic clk);
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [5:0]         bin_index;
  logic signed [31:0] operand;
  modport source (output valid, action, bin_index, operand, input ready);
  modport sink (input valid, action, bin_index, operand, output ready);
endinterface

interface whist_rsp_if import whist_pkg::*; (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [17:0] probability;
  logic signed [39:0] total_sum;
  modport source (output valid, probability, total_sum, input ready);
  modport sink (input valid, probability, total_sum, output ready);
endinterface

@@ design/whist_front.sv @@
// Front end: accepts requests, checks the index and queues commands.
module whist_front import whist_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [CFG_W-1:0] entries,
  whist_req_if.sink       req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output cmd_t            cmd
);

  cmd_t q [QUEUE_DEPTH];
  logic [0:0] wp, rp;
  logic [1:0] count;
  logic known, push, pop, in_range;
  cmd_t c;

  always_comb begin
    in_range = (CFG_W'(req.bin_index) < entries) && (32'(req.bin_index) < NUM_ENTRIES);
    known = 1'b1;
    c.idx = IDX_W'(req.bin_index);
    c.operand = req.operand;
    c.valid_idx = in_range;
    c.wmode = WM_SET;
    c.op = OP_WRITE;
    case (action_t'(req.action))
      ACT_SET:   c.wmode = WM_SET;
      ACT_INC:   c.wmode = WM_INC;
      ACT_ADD:   c.wmode = WM_ADD;
      ACT_SCALE: c.op = OP_SCALE;
      ACT_QUERY: c.op = OP_QUERY;
      default:   known = 1'b0;
    endcase
  end

  assign req.ready = (count != 2'(QUEUE_DEPTH));
  assign push = req.valid && req.ready && known;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) q[wp] <= c;
  end

endmodule

@@ design/whist_div.sv @@
// Restoring divider: signed 48-bit numerator over 40-bit divisor, one bit a cycle.
module whist_div import whist_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic signed [39:0] den,
  output logic               done,
  output logic signed [17:0] quot
);

  logic [47:0] n_abs, q;
  logic [39:0] d_abs;
  logic [40:0] rem;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [41:0] trial;
  logic [40:0] rsh;
  logic signed [48:0] sq;

  assign rsh = {rem[39:0], n_abs[47]};
  assign trial = {1'b0, rsh} - {2'b0, d_abs};

  always_comb begin
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (sq > 49'(PROB_MAX)) quot = PROB_MAX;
    else if (sq < 49'(PROB_MIN)) quot = PROB_MIN;
    else quot = sq[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n_abs <= num[47] ? 48'(-num) : num;
        d_abs <= den[39] ? 40'(-den) : den;
        neg <= num[47] ^ den[39];
        rem <= '0;
        q <= '0;
        cnt <= 6'd48;
      end else if (busy) begin
        n_abs <= {n_abs[46:0], 1'b0};
        if (!trial[41]) begin
          rem <= trial[40:0];
          q <= {q[46:0], 1'b1};
        end else begin
          rem <= rsh;
          q <= {q[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/whist_back.sv @@
// Back end: bin memory, read-modify-write, scale sweep and query.
module whist_back import whist_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  whist_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_WRITE, S_SREAD, S_SMUL, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic signed [31:0] mem [NUM_ENTRIES];
  logic signed [31:0] rdata;
  logic [IDX_W-1:0] raddr, sidx;
  logic [CNT_W-1:0] ccnt;
  cmd_t cur;
  logic signed [39:0] total;
  logic signed [47:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] nv, scaled;
  logic signed [47:0] wanted;
  logic signed [17:0] prob;
  logic div_start, div_done;
  logic signed [17:0] div_q;
  logic signed [63:0] rounded;

  whist_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({rdata, 16'h0}), .den(total), .done(div_done), .quot(div_q)
  );

  assign cmd_ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.probability = prob;
  assign rsp.total_sum = total;
  assign div_start = (state == S_READ) && cur.op == OP_QUERY && cur.valid_idx
                     && total != 40'sd0;

  // read address is set in the state before, so the registered rdata is valid in the next state
  always_comb begin
    case (state)
      S_IDLE:  raddr = (cmd.op == OP_SCALE) ? '0 : cmd.idx;
      S_SMUL:  raddr = sidx + 1'b1;
      default: raddr = cur.idx;
    endcase
  end

  always_comb begin
    case (cur.wmode)
      WM_INC:  wanted = 48'(rdata) + 48'(ONE_Q16);
      WM_ADD:  wanted = 48'(rdata) + 48'(cur.operand);
      default: wanted = 48'(cur.operand);
    endcase
    nv = sat32(wanted);
    rounded = (prod + 64'sd32768) >>> 16;
    if (rounded > 64'sh7FFF_FFFF) scaled = 32'sh7FFF_FFFF;
    else if (rounded < -64'sh8000_0000) scaled = 32'sh8000_0000;
    else scaled = rounded[31:0];
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (rst) begin
      state <= S_CLEAR;
      ccnt <= '0;
      total <= '0;
      sidx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          mem[IDX_W'(ccnt)] <= '0;
          ccnt <= ccnt + 1'b1;
          if (ccnt == CNT_W'(NUM_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          sidx <= '0;
          acc <= '0;
          if (cmd.op == OP_SCALE) begin
            state <= S_SREAD;
          end else state <= S_READ;
        end
        S_READ: begin
          if (cur.op == OP_QUERY) begin
            prob <= '0;
            state <= div_start ? S_DIV : S_OUT;
          end else if (cur.valid_idx) state <= S_WRITE;
          else state <= S_IDLE;
        end
        S_WRITE: begin
          mem[cur.idx] <= nv;
          total <= sat40(48'(total) + 48'(nv) - 48'(rdata));
          state <= S_IDLE;
        end
        S_SREAD: begin
          prod <= 64'(rdata) * 64'(cur.operand);
          state <= S_SMUL;
        end
        S_SMUL: begin
          mem[sidx] <= scaled;
          acc <= acc + 48'(scaled);
          if (32'(sidx) == NUM_ENTRIES - 1) begin
            total <= sat40(acc + 48'(scaled));
            state <= S_IDLE;
          end else begin
            sidx <= sidx + 1'b1;
            state <= S_SREAD;
          end
        end
        S_DIV: if (div_done) begin
          prob <= div_q;
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/weighted_histogram_table.sv @@
// Weighted histogram table top level.
// Requests arrive on req (action, bin_index, operand) with valid/ready; a
// request is taken when both are high. Only a query produces a result on rsp
// (probability in signed Q2.16, total_sum in Q24.16).
// entries_in_use (reset 64) is written through cfg_we/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// Requests go into a two-entry command queue; the back end runs them against
// a 64-entry bin memory. Set/increment/add: read, then modify-write the bin.
// Scale: for each bin in turn, a read-and-multiply state, then a write state.
// Query: runs the bit-serial 48-step divider; a query with zero total or
// invalid index skips the divider and returns probability 0.
// After reset the back end clears all 64 bins; requests queue up (two deep)
// meanwhile. When rsp is stalled the result is held and the back end waits;
// the queue keeps accepting until full.
module weighted_histogram_table import whist_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  whist_req_if.sink        req,
  whist_rsp_if.source      rsp
);

  logic [CFG_W-1:0] entries_in_use;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) entries_in_use <= CFG_W'(64);
    else if (cfg_we) entries_in_use <= cfg_data;
  end

  whist_front u_front (
    .clk(clk), .rst(rst), .entries(entries_in_use), .req(req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  whist_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .rsp(rsp)
  );

endmodule
